### rtl/core/bis_pkg.sv
`timescale 1ns / 1ps
// bis_pkg: shared constants, types and arithmetic helpers for the bilinear image sampler
// depends on nothing; used by every file in rtl/core except bis_ram

package bis_pkg;

  // image store geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field widths
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 8;
  localparam int CH_W      = 8;
  localparam int CHANNELS  = 3;
  localparam int PIX_W     = CH_W * CHANNELS;
  localparam int COORD_W   = 17;
  localparam int FRAC_W    = 16;
  localparam int SIZE_W    = 9;
  localparam int SCALED_W  = COORD_W + SIZE_W;
  localparam int ACC_W     = CH_W + FRAC_W;
  localparam int MIX_W     = ACC_W + FRAC_W + 2;
  localparam int OUT_W     = 16;

  // coordinate of one, 16 fraction bits
  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1 << FRAC_W);

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = SIZE_W;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  // command codes on the request channel
  localparam logic [CMD_W-1:0] CMD_WRITE  = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_SAMPLE = CMD_W'(2);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // four taps per sample
  localparam int TAPS  = 4;
  localparam int TAP_W = $clog2(TAPS);
  localparam logic [TAP_W-1:0] TAP_FIRST  = TAP_W'(0);
  localparam logic [TAP_W-1:0] TAP_RIGHT  = TAP_W'(1);
  localparam logic [TAP_W-1:0] TAP_BELOW  = TAP_W'(2);
  localparam logic [TAP_W-1:0] TAP_LAST   = TAP_W'(TAPS - 1);

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_REJECT = 2'd3
  } op_kind_t;

  // classified item as it travels through the queue
  typedef struct packed {
    op_kind_t             kind;
    logic [IDX_W-1:0]     x0;
    logic [IDX_W-1:0]     x1;
    logic [IDX_W-1:0]     y0;
    logic [IDX_W-1:0]     y1;
    logic [FRAC_W-1:0]    fx;
    logic [FRAC_W-1:0]    fy;
    logic [PIX_W-1:0]     pixel;
  } op_t;

  typedef logic [CHANNELS-1:0][ACC_W-1:0] acc_vec_t;
  typedef logic signed [MIX_W-1:0]        mix_t;

  // byte k of a pixel, red first
  function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] px, input int k);
    chan = px[(CHANNELS - 1 - k) * CH_W +: CH_W];
  endfunction

  // a*(1-f) + b*f written as a*one + (b-a)*f, exact
  function automatic logic [ACC_W-1:0] blend_chan(input logic [CH_W-1:0] a,
                                                   input logic [CH_W-1:0] b,
                                                   input logic [FRAC_W-1:0] f);
    logic signed [CH_W:0]     d;
    logic signed [ACC_W+1:0]  p;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, f});
    p = p + $signed({2'b00, a, {FRAC_W{1'b0}}});
    blend_chan = p[ACC_W-1:0];
  endfunction

  // (hi - lo) * fy, first half of the vertical blend
  function automatic mix_t mix_chan(input logic [ACC_W-1:0] lo,
                                    input logic [ACC_W-1:0] hi,
                                    input logic [FRAC_W-1:0] f);
    logic signed [ACC_W:0] d;
    mix_t                  p;
    d = $signed({1'b0, hi}) - $signed({1'b0, lo});
    p = d * $signed({1'b0, f});
    mix_chan = p;
  endfunction

  // lo*one + product, rounded once to 8 fraction bits
  function automatic logic [OUT_W-1:0] round_chan(input logic [ACC_W-1:0] lo,
                                                  input mix_t prod);
    mix_t s;
    s = $signed({2'b00, lo, {FRAC_W{1'b0}}}) + prod + mix_t'(1 << (2 * FRAC_W - CH_W - 1));
    round_chan = s[2 * FRAC_W - CH_W +: OUT_W];
  endfunction

endpackage

### rtl/core/bis_req_if.sv
`timescale 1ns / 1ps
// bis_req_if: request channel of the bilinear image sampler (valid/ready plus item fields)
// depends on bis_pkg

interface bis_req_if;
  logic                          valid;
  logic                          ready;
  logic [bis_pkg::CMD_W-1:0]     command;
  logic [bis_pkg::IDX_W-1:0]     column;
  logic [bis_pkg::IDX_W-1:0]     row;
  logic [bis_pkg::CH_W-1:0]      red_in;
  logic [bis_pkg::CH_W-1:0]      green_in;
  logic [bis_pkg::CH_W-1:0]      blue_in;
  logic [bis_pkg::COORD_W-1:0]   coord_u;
  logic [bis_pkg::COORD_W-1:0]   coord_v;

  modport source (
    output valid, command, column, row, red_in, green_in, blue_in, coord_u, coord_v,
    input  ready
  );
  modport sink (
    input  valid, command, column, row, red_in, green_in, blue_in, coord_u, coord_v,
    output ready
  );
endinterface

### rtl/core/bis_rsp_if.sv
`timescale 1ns / 1ps
// bis_rsp_if: response channel of the bilinear image sampler (valid/ready plus result fields)
// depends on bis_pkg

interface bis_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bis_pkg::OUT_W-1:0]   red_out;
  logic [bis_pkg::OUT_W-1:0]   green_out;
  logic [bis_pkg::OUT_W-1:0]   blue_out;
  logic                        out_of_range;

  modport source (
    output valid, red_out, green_out, blue_out, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, out_of_range,
    output ready
  );
endinterface

### rtl/core/bilinear_image_sampler_unit.sv
`timescale 1ns / 1ps
// bilinear_image_sampler_unit: top level, joins front, queue and back
// depends on bis_pkg, bis_req_if, bis_rsp_if, bis_front, bis_queue, bis_back

// Keeps a 256 x 256 RGB byte image in a single-port pixel store and answers each
// request (write pixel, read pixel, bilinear sample at u,v in 1.16 fixed point)
// with exactly one response carrying colours with 8 fraction bits and an
// out-of-range flag. Writes, reads and rejected items take one fetch slot, and
// writes and reads use the store port in that slot. A sample occupies the
// port for four accesses, one per neighbouring pixel. While the response is
// taken, the other commands are sustained at one per cycle. A response passes
// from the queue through the fetch, data return, horizontal results and
// vertical product stages into the response register. The front takes requests
// while a two-entry queue has room, so it keeps accepting while the back is busy
// or the response waits. The store has no reset and no clearing pass: a pixel
// must be written before it is read or sampled. The user must write the size
// registers only while the block is idle; the block itself does not enforce it.

module bilinear_image_sampler_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]   cfg_data,
  bis_req_if.sink                          request,
  bis_rsp_if.source                        response
);

  logic          push;
  bis_pkg::op_t  push_op;
  logic          queue_full;
  logic          head_valid;
  bis_pkg::op_t  head_op;
  logic          pop;

  // accept and classify
  bis_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .request    (request),
    .queue_full (queue_full),
    .push       (push),
    .push_op    (push_op)
  );

  // decoupling queue
  bis_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop)
  );

  // store access, blend and response
  bis_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .response   (response)
  );

endmodule

### rtl/core/bis_ram.sv
`timescale 1ns / 1ps
// bis_ram: generic single-port RAM with registered read
// depends on nothing

module bis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read data held while disabled
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### rtl/core/bis_front.sv
`timescale 1ns / 1ps
// bis_front: size registers, request acceptance and classification into queue entries
// depends on bis_pkg and bis_req_if

module bis_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_data,
  bis_req_if.sink                           request,
  input  logic                              queue_full,
  output logic                              push,
  output bis_pkg::op_t                      push_op
);

  logic [bis_pkg::SIZE_W-1:0]   width_reg;
  logic [bis_pkg::SIZE_W-1:0]   height_reg;
  logic [bis_pkg::SIZE_W-1:0]   w_eff;
  logic [bis_pkg::SIZE_W-1:0]   h_eff;
  logic [bis_pkg::SIZE_W-1:0]   w_last;
  logic [bis_pkg::SIZE_W-1:0]   h_last;
  logic [bis_pkg::SCALED_W-1:0] xs;
  logic [bis_pkg::SCALED_W-1:0] ys;
  logic [bis_pkg::SCALED_W-bis_pkg::FRAC_W-1:0] x_int;
  logic [bis_pkg::SCALED_W-bis_pkg::FRAC_W-1:0] y_int;
  logic [bis_pkg::SIZE_W-1:0]   x0c;
  logic [bis_pkg::SIZE_W-1:0]   y0c;
  logic [bis_pkg::SIZE_W-1:0]   x1c;
  logic [bis_pkg::SIZE_W-1:0]   y1c;
  logic                         pix_outside;
  logic                         coord_outside;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= bis_pkg::SIZE_RESET;
      height_reg <= bis_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bis_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
        bis_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective size: zero acts as one, oversize acts as the store maximum
  always_comb begin
    if (width_reg == '0) begin
      w_eff = bis_pkg::SIZE_W'(1);
    end else if (width_reg > bis_pkg::SIZE_W'(bis_pkg::MAX_WIDTH)) begin
      w_eff = bis_pkg::SIZE_W'(bis_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_reg;
    end
    if (height_reg == '0) begin
      h_eff = bis_pkg::SIZE_W'(1);
    end else if (height_reg > bis_pkg::SIZE_W'(bis_pkg::MAX_HEIGHT)) begin
      h_eff = bis_pkg::SIZE_W'(bis_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_reg;
    end
    w_last = w_eff - bis_pkg::SIZE_W'(1);
    h_last = h_eff - bis_pkg::SIZE_W'(1);
  end

  // scale coordinates by image size, 16 fraction bits kept
  assign xs    = bis_pkg::SCALED_W'(request.coord_u) * bis_pkg::SCALED_W'(w_eff);
  assign ys    = bis_pkg::SCALED_W'(request.coord_v) * bis_pkg::SCALED_W'(h_eff);
  assign x_int = xs[bis_pkg::SCALED_W-1:bis_pkg::FRAC_W];
  assign y_int = ys[bis_pkg::SCALED_W-1:bis_pkg::FRAC_W];

  // floor cell clamped to the last pixel, neighbour clamped likewise
  always_comb begin
    x0c = (x_int > ($bits(x_int))'(w_last)) ? w_last : x_int[bis_pkg::SIZE_W-1:0];
    y0c = (y_int > ($bits(y_int))'(h_last)) ? h_last : y_int[bis_pkg::SIZE_W-1:0];
    x1c = (x0c + bis_pkg::SIZE_W'(1) > w_last) ? w_last : x0c + bis_pkg::SIZE_W'(1);
    y1c = (y0c + bis_pkg::SIZE_W'(1) > h_last) ? h_last : y0c + bis_pkg::SIZE_W'(1);
  end

  assign pix_outside   = ({1'b0, request.column} >= w_eff) || ({1'b0, request.row} >= h_eff);
  assign coord_outside = (request.coord_u > bis_pkg::COORD_ONE) ||
                         (request.coord_v > bis_pkg::COORD_ONE);

  // classify the item
  always_comb begin
    push_op.x0    = request.column;
    push_op.x1    = request.column;
    push_op.y0    = request.row;
    push_op.y1    = request.row;
    push_op.fx    = '0;
    push_op.fy    = '0;
    push_op.pixel = {request.red_in, request.green_in, request.blue_in};
    push_op.kind  = bis_pkg::OP_REJECT;
    case (request.command)
      bis_pkg::CMD_WRITE: begin
        push_op.kind = pix_outside ? bis_pkg::OP_REJECT : bis_pkg::OP_WRITE;
      end
      bis_pkg::CMD_READ: begin
        push_op.kind = pix_outside ? bis_pkg::OP_REJECT : bis_pkg::OP_READ;
      end
      bis_pkg::CMD_SAMPLE: begin
        push_op.kind = coord_outside ? bis_pkg::OP_REJECT : bis_pkg::OP_SAMPLE;
        push_op.x0   = x0c[bis_pkg::IDX_W-1:0];
        push_op.x1   = x1c[bis_pkg::IDX_W-1:0];
        push_op.y0   = y0c[bis_pkg::IDX_W-1:0];
        push_op.y1   = y1c[bis_pkg::IDX_W-1:0];
        push_op.fx   = xs[bis_pkg::FRAC_W-1:0];
        push_op.fy   = ys[bis_pkg::FRAC_W-1:0];
      end
      default: begin
        push_op.kind = bis_pkg::OP_REJECT;
      end
    endcase
  end

  // transfer into the queue whenever it has room
  assign request.ready = !queue_full;
  assign push          = request.valid && !queue_full;

endmodule

### rtl/core/bis_queue.sv
`timescale 1ns / 1ps
// bis_queue: short FIFO of classified items between front and back
// depends on bis_pkg

module bis_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bis_pkg::op_t  push_op,
  output logic          full,
  output logic          head_valid,
  output bis_pkg::op_t  head_op,
  input  logic          pop
);

  bis_pkg::op_t                entries [bis_pkg::QUEUE_DEPTH];
  logic [bis_pkg::QPTR_W-1:0]  wr_ptr;
  logic [bis_pkg::QPTR_W-1:0]  rd_ptr;
  logic [bis_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign full       = (count == bis_pkg::QCNT_W'(bis_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == bis_pkg::QPTR_W'(bis_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + bis_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == bis_pkg::QPTR_W'(bis_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + bis_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + bis_pkg::QCNT_W'(1);
        2'b01:   count <= count - bis_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/bis_back.sv
`timescale 1ns / 1ps
// bis_back: pixel store access sequencer, blend pipeline and response register
// depends on bis_pkg, bis_rsp_if and bis_ram

module bis_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  bis_pkg::op_t  head_op,
  output logic          pop,
  bis_rsp_if.source     response
);

  // whole pipeline moves when the response register is free or being taken
  logic                           adv;

  // fetch stage
  logic                           f_valid;
  bis_pkg::op_t                   f_op;
  logic [bis_pkg::TAP_W-1:0]      f_cnt;
  logic                           f_last;
  logic                           issue;
  logic [bis_pkg::IDX_W-1:0]      x_sel;
  logic [bis_pkg::IDX_W-1:0]      y_sel;
  logic                           ram_en;
  logic                           ram_we;
  logic [bis_pkg::ADDR_W-1:0]     ram_addr;
  logic [bis_pkg::PIX_W-1:0]      ram_rdata;

  // data return stage
  logic                           d_valid;
  bis_pkg::op_kind_t              d_kind;
  logic [bis_pkg::TAP_W-1:0]      d_tag;
  logic [bis_pkg::FRAC_W-1:0]     d_fx;
  logic [bis_pkg::FRAC_W-1:0]     d_fy;
  logic [bis_pkg::PIX_W-1:0]      p00;
  logic [bis_pkg::PIX_W-1:0]      p10;
  bis_pkg::acc_vec_t              lo_acc;
  logic                           d_sample;

  // horizontal results stage
  logic                           m_valid;
  logic                           m_flag;
  logic [bis_pkg::FRAC_W-1:0]     m_fy;
  bis_pkg::acc_vec_t              m_lo;
  bis_pkg::acc_vec_t              m_hi;

  // vertical product stage
  logic                           p_valid;
  logic                           p_flag;
  bis_pkg::acc_vec_t              p_lo;
  bis_pkg::mix_t                  p_prod [bis_pkg::CHANNELS];

  assign adv = !response.valid || response.ready;

  // fetch sequencer: one access for write or read, none for a rejected item, four taps for a sample
  assign f_last = (f_op.kind != bis_pkg::OP_SAMPLE) || (f_cnt == bis_pkg::TAP_LAST);
  assign pop    = adv && (!f_valid || f_last) && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      if (!f_valid || f_last) begin
        f_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!f_valid || f_last) begin
        f_op  <= head_op;
        f_cnt <= '0;
      end else begin
        f_cnt <= f_cnt + bis_pkg::TAP_W'(1);
      end
    end
  end

  // tap order: floor, right, below, below right
  assign issue    = adv && f_valid;
  assign x_sel    = f_cnt[0] ? f_op.x1 : f_op.x0;
  assign y_sel    = f_cnt[1] ? f_op.y1 : f_op.y0;
  assign ram_addr = bis_pkg::ADDR_W'(y_sel) * bis_pkg::ADDR_W'(bis_pkg::MAX_WIDTH) +
                    bis_pkg::ADDR_W'(x_sel);
  assign ram_en   = issue && (f_op.kind != bis_pkg::OP_REJECT);
  assign ram_we   = (f_op.kind == bis_pkg::OP_WRITE);

  bis_ram #(
    .WIDTH (bis_pkg::PIX_W),
    .DEPTH (bis_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (f_op.pixel),
    .rdata (ram_rdata)
  );

  // token registered behind the access
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_kind <= f_op.kind;
      d_tag  <= f_cnt;
      d_fx   <= f_op.fx;
      d_fy   <= f_op.fy;
    end
  end

  assign d_sample = d_valid && (d_kind == bis_pkg::OP_SAMPLE);

  // collect taps, blend the upper row as soon as its right pixel arrives
  always_ff @(posedge clk) begin
    if (adv && d_sample) begin
      case (d_tag)
        bis_pkg::TAP_FIRST: p00 <= ram_rdata;
        bis_pkg::TAP_RIGHT: begin
          for (int k = 0; k < bis_pkg::CHANNELS; k++) begin
            lo_acc[k] <= bis_pkg::blend_chan(bis_pkg::chan(p00, k),
                                             bis_pkg::chan(ram_rdata, k), d_fx);
          end
        end
        bis_pkg::TAP_BELOW: p10 <= ram_rdata;
        default: ;
      endcase
    end
  end

  // horizontal results: lower row blend beside the upper for samples, pixel for reads, zero otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= d_valid && ((d_kind != bis_pkg::OP_SAMPLE) || (d_tag == bis_pkg::TAP_LAST));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_flag <= (d_kind == bis_pkg::OP_REJECT);
      m_fy   <= (d_kind == bis_pkg::OP_SAMPLE) ? d_fy : '0;
      for (int k = 0; k < bis_pkg::CHANNELS; k++) begin
        case (d_kind)
          bis_pkg::OP_SAMPLE: begin
            m_lo[k] <= lo_acc[k];
            m_hi[k] <= bis_pkg::blend_chan(bis_pkg::chan(p10, k),
                                           bis_pkg::chan(ram_rdata, k), d_fx);
          end
          bis_pkg::OP_READ: begin
            m_lo[k] <= {bis_pkg::chan(ram_rdata, k), {bis_pkg::FRAC_W{1'b0}}};
            m_hi[k] <= {bis_pkg::chan(ram_rdata, k), {bis_pkg::FRAC_W{1'b0}}};
          end
          default: begin
            m_lo[k] <= '0;
            m_hi[k] <= '0;
          end
        endcase
      end
    end
  end

  // vertical product
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_flag <= m_flag;
      p_lo   <= m_lo;
      for (int k = 0; k < bis_pkg::CHANNELS; k++) begin
        p_prod[k] <= bis_pkg::mix_chan(m_lo[k], m_hi[k], m_fy);
      end
    end
  end

  // rounding into the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (adv) begin
      response.valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      response.red_out      <= bis_pkg::round_chan(p_lo[0], p_prod[0]);
      response.green_out    <= bis_pkg::round_chan(p_lo[1], p_prod[1]);
      response.blue_out     <= bis_pkg::round_chan(p_lo[2], p_prod[2]);
      response.out_of_range <= p_flag;
    end
  end

endmodule
